// ===== hw/rtl/button_short_long_press_toggler_top_defines.svh =====
// Assertion macros used by the button toggler RTL.
// Depends on nothing; included by bslt_core, the module that carries concurrent checks.
`ifndef BUTTON_SHORT_LONG_PRESS_TOGGLER_TOP_DEFINES_SVH
`define BUTTON_SHORT_LONG_PRESS_TOGGLER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bslt: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BSLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bslt: next-cycle check failed");

`endif

// ===== hw/rtl/bslt_pkg.sv =====
// Shared widths, register indexes, reset values and types for the button toggler.
// Depends on nothing; used by the interfaces and all modules.
package bslt_pkg;

    localparam int TIME_W    = 32;
    localparam int MS_W      = 16;
    localparam int PHASE_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PRESSED    = 2'd2;

    localparam logic [MS_W-1:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [MS_W-1:0] LONG_PRESS_RST = 16'd3000;
    localparam logic            PRESSED_RST    = 1'b0;

    typedef struct packed {
        logic [MS_W-1:0] debounce_ms;
        logic [MS_W-1:0] long_press_ms;
        logic            pressed_level;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] now_ms;
        logic              key_pin;
        logic              edge_seen;
    } t_poll;

endpackage

// ===== hw/rtl/bslt_ifs.sv =====
// Handshake channel interfaces: poll requests, results and register writes.
// Depends on bslt_pkg for field widths.
interface bslt_in_if;
    logic                       valid;
    logic                       ready;
    logic [bslt_pkg::TIME_W-1:0] now_ms;
    logic                       key_pin;
    logic                       edge_seen;

    modport source (output valid, output now_ms, output key_pin, output edge_seen,
                    input ready);
    modport sink   (input valid, input now_ms, input key_pin, input edge_seen,
                    output ready);
endinterface

interface bslt_out_if;
    logic                         valid;
    logic                         ready;
    logic                         power_out;
    logic                         backlight_out;
    logic [bslt_pkg::PHASE_W-1:0] phase;

    modport source (output valid, output power_out, output backlight_out, output phase,
                    input ready);
    modport sink   (input valid, input power_out, input backlight_out, input phase,
                    output ready);
endinterface

interface bslt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bslt_pkg::CFG_IDX_W-1:0] index;
    logic [bslt_pkg::MS_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/button_short_long_press_toggler_top.sv =====
// A poll request accepted into the input register moves on to the result registers when the core takes it.
// Throughput: one request per cycle; the input register holds one request while a
// result stalls, and intake stops once both the input and result registers are full.
// Reset: synchronous active-low; phase idle, power on, backlight off, no pending
// edge, timing registers default (debounce 20 ms, long press 3000 ms, pressed low).
module button_short_long_press_toggler_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bslt_cfg_if.sink i_cfg,
    bslt_in_if.sink  i_in,
    bslt_out_if.source o_out
);
    import bslt_pkg::*;

    // Current configuration, held in its own register file.
    t_cfg  w_cfg;
    // Registered poll request waiting for the classifier.
    t_poll w_poll;
    // Classifier consumes the registered request this cycle.
    logic  w_take;

    // Register writes are always accepted; an index past the list is dropped.
    bslt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Hold each incoming poll until the classifier takes it; refill in the
    // same cycle so back-to-back requests stream without a bubble.
    bslt_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_poll  (w_poll)
    );

    // Advance the phase machine by one poll and present the updated levels and
    // phase as the result; stall the take while a result waits unread.
    bslt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_poll  (w_poll),
        .o_take  (w_take),
        .o_out   (o_out)
    );

endmodule

// ===== hw/rtl/bslt_cfg.sv =====
// Configuration register file: debounce time, long-press time, pressed level.
// Depends on bslt_pkg and bslt_ifs.
module bslt_cfg (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bslt_cfg_if.sink     i_cfg,
    output bslt_pkg::t_cfg o_cfg
);
    import bslt_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_IDX_DEBOUNCE:   n_cfg.debounce_ms   = i_cfg.data;
                CFG_IDX_LONG_PRESS: n_cfg.long_press_ms = i_cfg.data;
                CFG_IDX_PRESSED:    n_cfg.pressed_level = i_cfg.data[0];
                default:            n_cfg = r_cfg; // unused index: drop
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= DEBOUNCE_RST;
            r_cfg.long_press_ms <= LONG_PRESS_RST;
            r_cfg.pressed_level <= PRESSED_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== hw/rtl/bslt_in_stage.sv =====
// Input register for poll requests; frees itself when the core takes the request.
// Depends on bslt_pkg and bslt_ifs.
module bslt_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bslt_in_if.sink         i_in,
    input  logic            i_take,
    output bslt_pkg::t_poll o_poll
);
    import bslt_pkg::*;

    t_poll r_poll;
    logic  w_accept;

    assign i_in.ready = !r_poll.valid || i_take;
    assign w_accept   = i_in.valid && i_in.ready;
    assign o_poll     = r_poll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll.valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_poll.valid     <= 1'b1;
                r_poll.now_ms    <= i_in.now_ms;
                r_poll.key_pin   <= i_in.key_pin;
                r_poll.edge_seen <= i_in.edge_seen;
            end else if (i_take) begin
                r_poll.valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/bslt_core.sv =====
// Press classifier: phase machine, time marks and output levels, updated once per request.
// Depends on bslt_pkg, bslt_ifs and the assertion macro header.
`include "button_short_long_press_toggler_top_defines.svh"

module bslt_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bslt_pkg::t_cfg  i_cfg,
    input  bslt_pkg::t_poll i_poll,
    output logic            o_take,
    bslt_out_if.source      o_out
);
    import bslt_pkg::*;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE      = 2'd0,
        PH_DEBOUNCE  = 2'd1,
        PH_PRESSED   = 2'd2,
        PH_LONG_DONE = 2'd3
    } t_phase_e;

    t_phase_e          r_phase,  n_phase;
    logic              r_edge_pending, n_edge_pending;
    logic [TIME_W-1:0] r_db_start, n_db_start;
    logic [TIME_W-1:0] r_press_start, n_press_start;
    logic              r_power, n_power;
    logic              r_backlight, n_backlight;
    logic              r_out_valid;

    logic              w_pressed;
    logic              w_pending;
    logic [TIME_W-1:0] w_db_elapsed;
    logic [TIME_W-1:0] w_press_elapsed;
    logic              w_db_done;
    logic              w_long_done;

    // The state registers are the result register: they change only on a take,
    // which needs the result slot free or drained in the same cycle.
    assign o_take = i_poll.valid && (!r_out_valid || o_out.ready);

    assign o_out.valid         = r_out_valid;
    assign o_out.power_out     = r_power;
    assign o_out.backlight_out = r_backlight;
    assign o_out.phase         = r_phase;

    assign w_pressed       = (i_poll.key_pin == i_cfg.pressed_level);
    assign w_pending       = r_edge_pending || i_poll.edge_seen;
    assign w_db_elapsed    = i_poll.now_ms - r_db_start;
    assign w_press_elapsed = i_poll.now_ms - r_press_start;
    assign w_db_done       = (w_db_elapsed >= {{(TIME_W-MS_W){1'b0}}, i_cfg.debounce_ms});
    assign w_long_done     = (w_press_elapsed >= {{(TIME_W-MS_W){1'b0}}, i_cfg.long_press_ms});

    always_comb begin
        n_phase        = r_phase;
        n_edge_pending = w_pending;
        n_db_start     = r_db_start;
        n_press_start  = r_press_start;
        n_power        = r_power;
        n_backlight    = r_backlight;
        unique case (r_phase)
            PH_IDLE: begin
                n_edge_pending = 1'b0;
                if (w_pending && w_pressed) begin
                    n_db_start = i_poll.now_ms;
                    n_phase    = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                if (w_db_done) begin
                    if (w_pressed) begin
                        n_press_start = i_poll.now_ms;
                        n_phase       = PH_PRESSED;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_PRESSED: begin
                if (!w_pressed) begin
                    n_backlight = !r_backlight;
                    n_phase     = PH_IDLE;
                end else if (w_long_done) begin
                    n_power = !r_power;
                    n_phase = PH_LONG_DONE;
                end
            end
            PH_LONG_DONE: begin
                if (!w_pressed) begin
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_edge_pending <= 1'b0;
            r_db_start     <= '0;
            r_press_start  <= '0;
            r_power        <= 1'b1;
            r_backlight    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase        <= n_phase;
                r_edge_pending <= n_edge_pending;
                r_db_start     <= n_db_start;
                r_press_start  <= n_press_start;
                r_power        <= n_power;
                r_backlight    <= n_backlight;
                r_out_valid    <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `BSLT_ASSERT_NOW(a_take_has_room, i_clk, i_rst_n, o_take, !r_out_valid || o_out.ready)
    `BSLT_ASSERT_NEXT(a_hold_without_take, i_clk, i_rst_n, !o_take,
        $stable(r_phase) && $stable(r_power) && $stable(r_backlight))
    `BSLT_ASSERT_NEXT(a_long_done_exit, i_clk, i_rst_n, r_phase == PH_LONG_DONE,
        r_phase == PH_LONG_DONE || r_phase == PH_IDLE)
    `BSLT_ASSERT_NEXT(a_power_once, i_clk, i_rst_n, r_phase == PH_LONG_DONE, $stable(r_power))
    `BSLT_ASSERT_NEXT(a_backlight_on_release, i_clk, i_rst_n, r_phase != PH_PRESSED,
        $stable(r_backlight))

endmodule

// ===== sim/button_short_long_press_toggler_top_tb.sv =====
// Self-checking testbench for button_short_long_press_toggler_top: directed table, then random presses.
// Depends on bslt_pkg, the handshake interfaces in bslt_ifs.sv and the top-level RTL.
module button_short_long_press_toggler_top_tb;
    import bslt_pkg::*;

    // Hard stop: the limit leaves ample room for the slowest legal run (every request and
    // result stalled for the longest drawn gap, plus drains between register settings).
    localparam int LIMIT_CYCLES    = 400000;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int N_ROWS          = 30;

    // Index 3 decodes to no register; writes there must leave the settings alone.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    typedef enum logic [PHASE_W-1:0] {
        PHASE_IDLE      = 2'd0,
        PHASE_DEBOUNCE  = 2'd1,
        PHASE_PRESSED   = 2'd2,
        PHASE_LONG_DONE = 2'd3
    } t_phase;

    // Output levels carried by one result.
    typedef struct packed {
        logic   power;
        logic   backlight;
        t_phase phase;
    } t_levels;

    typedef enum logic {ROW_POLL, ROW_WRITE} t_row_kind;

    // One directed step: either a poll request or a register write.
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [MS_W-1:0]       reg_data;
        logic [TIME_W-1:0]     now_ms;
        logic                  key;
        logic                  edge_bit;
        logic                  typed;
        logic                  exp_power;
        logic                  exp_backlight;
        t_phase                exp_phase;
    } t_row;

    // Directed part, run with reset settings until the first write row:
    // after-reset polls, tick wrap inside debounce, long press, an edge latched
    // outside idle, a bounce back to idle, a short press, zero times with the
    // pressed level flipped (upper data bits dropped, index 3 ignored), and
    // both times at their maximum.
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'h0000_0000, 1'b1, 1'b0,
          1'b1, 1'b1, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'hFFFF_FFFF, 1'b1, 1'b1,
          1'b1, 1'b1, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'hFFFF_FFF0, 1'b0, 1'b1,
          1'b1, 1'b1, 1'b0, PHASE_DEBOUNCE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'hFFFF_FFFF, 1'b0, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'h0000_0004, 1'b0, 1'b1,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'd3003,      1'b0, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'd3004,      1'b0, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'd3005,      1'b1, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'd3006,      1'b1, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'd4000,      1'b0, 1'b1,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'd4010,      1'b1, 1'b1,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'd4020,      1'b1, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'd4021,      1'b0, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'd4041,      1'b0, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'd4100,      1'b1, 1'b1,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_WRITE, CFG_IDX_DEBOUNCE,   16'h0000, 32'd0,         1'b0, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_WRITE, CFG_IDX_LONG_PRESS, 16'h0000, 32'd0,         1'b0, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_WRITE, CFG_IDX_PRESSED,    16'hFFFF, 32'd0,         1'b0, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_WRITE, CFG_IDX_UNUSED,     16'h0000, 32'd0,         1'b0, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'd100,       1'b1, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'd100,       1'b1, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'd100,       1'b1, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'd100,       1'b0, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_WRITE, CFG_IDX_DEBOUNCE,   16'hFFFF, 32'd0,         1'b0, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_WRITE, CFG_IDX_LONG_PRESS, 16'hFFFF, 32'd0,         1'b0, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'd200,       1'b1, 1'b1,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'h0001_00C6, 1'b1, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'h0001_00C7, 1'b1, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'h0002_00C6, 1'b1, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE},
        '{ROW_POLL,  CFG_IDX_DEBOUNCE,   16'h0000, 32'h0002_00C7, 1'b0, 1'b0,
          1'b0, 1'b0, 1'b0, PHASE_IDLE}
    };

    logic clk;
    logic rst_n;

    bslt_in_if  poll_if();
    bslt_out_if result_if();
    bslt_cfg_if reg_if();

    button_short_long_press_toggler_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (reg_if),
        .i_in    (poll_if),
        .o_out   (result_if)
    );

    // Hand-typed expectation travels with the poll request it belongs to.
    logic    row_typed  = 1'b0;
    t_levels row_levels = '0;

    // Shared idle mode: when set, neither side inserts gaps.
    bit calm = 1'b0;

    int fail_count  = 0;
    int cycle_count = 0;

    // Expected output levels, oldest first.
    t_levels expected_levels[$];

    // Press classifier state and its copy of the settings.
    t_cfg              cfg_model      = '{DEBOUNCE_RST, LONG_PRESS_RST, PRESSED_RST};
    t_phase            press_phase    = PHASE_IDLE;
    logic              edge_latched   = 1'b0;
    logic [TIME_W-1:0] debounce_mark  = '0;
    logic [TIME_W-1:0] press_mark     = '0;
    logic              power_level    = 1'b1;
    logic              backlight_level = 1'b0;

    // Advance the press classifier by one poll and return the levels it shows.
    function automatic t_levels classify_poll(input logic [TIME_W-1:0] now,
                                              input logic key,
                                              input logic edge_bit);
        logic    down;
        t_levels levels;
        down = (key == cfg_model.pressed_level);
        edge_latched = edge_latched | edge_bit;
        case (press_phase)
            PHASE_IDLE: begin
                // Consume a pending edge only from idle.
                if (edge_latched) begin
                    edge_latched = 1'b0;
                    if (down) begin
                        debounce_mark = now;
                        press_phase   = PHASE_DEBOUNCE;
                    end
                end
            end
            PHASE_DEBOUNCE: begin
                // Elapsed time wraps modulo 2^32.
                if (TIME_W'(now - debounce_mark) >= TIME_W'(cfg_model.debounce_ms)) begin
                    if (down) begin
                        press_mark  = now;
                        press_phase = PHASE_PRESSED;
                    end else begin
                        press_phase = PHASE_IDLE;
                    end
                end
            end
            PHASE_PRESSED: begin
                if (down) begin
                    if (TIME_W'(now - press_mark) >= TIME_W'(cfg_model.long_press_ms)) begin
                        power_level = ~power_level;
                        press_phase = PHASE_LONG_DONE;
                    end
                end else begin
                    backlight_level = ~backlight_level;
                    press_phase     = PHASE_IDLE;
                end
            end
            default: begin
                if (!down) begin
                    press_phase = PHASE_IDLE;
                end
            end
        endcase
        levels.power     = power_level;
        levels.backlight = backlight_level;
        levels.phase     = press_phase;
        return levels;
    endfunction

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Scoreboard: check results first, then track register writes, then
    // predict for each accepted poll request. All sampled at the rising edge.
    always @(posedge clk) begin
        t_levels want;
        t_levels got;
        if (rst_n) begin
            if (result_if.valid && result_if.ready) begin
                if (expected_levels.size() == 0) begin
                    $error("unexpected result: power_out %0d backlight_out %0d phase %0d",
                           result_if.power_out, result_if.backlight_out, result_if.phase);
                    fail_count++;
                end else begin
                    want = expected_levels.pop_front();
                    if (result_if.power_out !== want.power) begin
                        $error("power_out: expected %0d, got %0d",
                               want.power, result_if.power_out);
                        fail_count++;
                    end
                    if (result_if.backlight_out !== want.backlight) begin
                        $error("backlight_out: expected %0d, got %0d",
                               want.backlight, result_if.backlight_out);
                        fail_count++;
                    end
                    if (result_if.phase !== want.phase) begin
                        $error("phase: expected %0d, got %0d", want.phase, result_if.phase);
                        fail_count++;
                    end
                end
            end
            if (reg_if.valid && reg_if.ready) begin
                case (reg_if.index)
                    CFG_IDX_DEBOUNCE:   cfg_model.debounce_ms   = reg_if.data;
                    CFG_IDX_LONG_PRESS: cfg_model.long_press_ms = reg_if.data;
                    CFG_IDX_PRESSED:    cfg_model.pressed_level = reg_if.data[0];
                    default: ;
                endcase
            end
            if (poll_if.valid && poll_if.ready) begin
                // Keep the classifier in step even when the row carries its own answer.
                got = classify_poll(poll_if.now_ms, poll_if.key_pin, poll_if.edge_seen);
                expected_levels.push_back(row_typed ? row_levels : got);
            end
        end
    end

    // Result side: hold ready low for a drawn number of cycles per result.
    initial begin
        int stall;
        result_if.ready = 1'b0;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                @(negedge clk) result_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk) result_if.ready <= 1'b1;
            do @(posedge clk); while (!result_if.valid);
        end
    end

    // Present one poll request after a drawn gap and wait until it is taken.
    // Valid stays high afterwards so back-to-back requests need no extra edge.
    task automatic send_poll(input logic [TIME_W-1:0] now, input logic key,
                             input logic edge_bit, input logic typed,
                             input t_levels typed_levels);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            @(negedge clk) poll_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        poll_if.valid     <= 1'b1;
        poll_if.now_ms    <= now;
        poll_if.key_pin   <= key;
        poll_if.edge_seen <= edge_bit;
        row_typed         <= typed;
        row_levels        <= typed_levels;
        do @(posedge clk); while (!poll_if.ready);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline settle.
    task automatic settle_idle();
        @(negedge clk) poll_if.valid <= 1'b0;
        while (expected_levels.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Issue one register write and drop valid after it is taken.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] data);
        @(negedge clk);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data  <= data;
        do @(posedge clk); while (!reg_if.ready);
        @(negedge clk) reg_if.valid <= 1'b0;
    endtask

    initial begin
        t_row              row;
        t_levels           typed_levels;
        logic [MS_W-1:0]   dbn;
        logic [MS_W-1:0]   lp;
        logic              pl;
        logic [MS_W-1:0]   reg_word;
        logic [TIME_W-1:0] tick;
        logic [TIME_W-1:0] toggle_mark;
        logic [TIME_W-1:0] hold_ms;
        logic [TIME_W-1:0] now;
        logic              key_down;
        logic              key;
        logic              edge_bit;
        int                step_max;

        // Drive every input to a known value from time zero.
        rst_n             = 1'b0;
        poll_if.valid     = 1'b0;
        poll_if.now_ms    = '0;
        poll_if.key_pin   = 1'b0;
        poll_if.edge_seen = 1'b0;
        reg_if.valid      = 1'b0;
        reg_if.index      = CFG_IDX_DEBOUNCE;
        reg_if.data       = '0;
        key_down          = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Walk the directed table; writes only go in once the block is drained.
        for (int r = 0; r < N_ROWS; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_WRITE) begin
                settle_idle();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                typed_levels.power     = row.exp_power;
                typed_levels.backlight = row.exp_backlight;
                typed_levels.phase     = row.exp_phase;
                send_poll(row.now_ms, row.key, row.edge_bit, row.typed, typed_levels);
            end
        end

        // Random part: one register setting per phase. Each phase starts from a
        // full drain, so the sender pauses until every result is back.
        for (int p = 0; p < N_PHASES; p++) begin
            settle_idle();
            case (p)
                0: begin
                    dbn = '0;
                    lp  = '0;
                end
                1: begin
                    dbn = '1;
                    lp  = '1;
                end
                2: begin
                    dbn = DEBOUNCE_RST;
                    lp  = LONG_PRESS_RST;
                end
                default: begin
                    if ($urandom_range(0, 1) == 0) begin
                        dbn = MS_W'($urandom_range(0, 64));
                        lp  = MS_W'($urandom_range(0, 64));
                    end else begin
                        dbn = MS_W'($urandom());
                        lp  = MS_W'($urandom());
                    end
                end
            endcase
            pl = 1'($urandom_range(0, 1));
            // Random upper bits on the level register must be dropped.
            reg_word    = MS_W'($urandom());
            reg_word[0] = pl;
            write_reg(CFG_IDX_DEBOUNCE, dbn);
            write_reg(CFG_IDX_LONG_PRESS, lp);
            write_reg(CFG_IDX_PRESSED, reg_word);
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_IDX_UNUSED, MS_W'($urandom()));
            end

            // Scale tick steps so a press spans a handful of polls at any setting.
            step_max    = (int'(dbn) + int'(lp)) / 6 + 1;
            tick        = ($urandom_range(0, 3) == 0) ?
                          32'hFFFF_FFFF - TIME_W'($urandom_range(0, step_max * 20)) :
                          $urandom();
            toggle_mark = tick;
            hold_ms     = '0;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Stretches with no idling on either side.
                if (n % 40 == 0) begin
                    calm = ($urandom_range(0, 3) == 0);
                end
                if ($urandom_range(0, 99) < 12) begin
                    // Noise: time jumps, contact bounce, spurious edges.
                    case ($urandom_range(0, 2))
                        0: begin
                            tick        = $urandom();
                            toggle_mark = tick;
                            key         = 1'($urandom_range(0, 1));
                            edge_bit    = 1'($urandom_range(0, 1));
                        end
                        1: begin
                            key      = 1'($urandom_range(0, 1));
                            edge_bit = 1'($urandom_range(0, 1));
                        end
                        default: begin
                            key      = key_down ? pl : ~pl;
                            edge_bit = 1'b1;
                        end
                    endcase
                    now = tick;
                end else begin
                    // Clean key: toggle once the drawn hold time has passed.
                    tick     = tick + TIME_W'($urandom_range(0, step_max));
                    edge_bit = 1'b0;
                    if (TIME_W'(tick - toggle_mark) >= hold_ms) begin
                        key_down    = ~key_down;
                        edge_bit    = 1'b1;
                        toggle_mark = tick;
                        if (key_down) begin
                            // Hold: shorter than debounce, short press, or long press.
                            case ($urandom_range(0, 2))
                                0: hold_ms = TIME_W'($urandom_range(0, dbn));
                                1: hold_ms = TIME_W'(dbn) + TIME_W'($urandom_range(0, lp));
                                default: hold_ms = TIME_W'(dbn) + TIME_W'(lp) +
                                                   TIME_W'($urandom_range(0, 3 * step_max));
                            endcase
                        end else begin
                            hold_ms = TIME_W'($urandom_range(0, int'(dbn) + 2 * step_max));
                        end
                    end
                    key = key_down ? pl : ~pl;
                    now = tick;
                end
                send_poll(now, key, edge_bit, 1'b0, '0);
            end
        end

        // Drain, give the pipeline its latency again, then report.
        calm = 1'b0;
        settle_idle();
        repeat (8) @(negedge clk);
        if (expected_levels.size() != 0) begin
            $error("%0d expected results never arrived", expected_levels.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bslt_pkg.sv
hw/rtl/bslt_ifs.sv
hw/rtl/bslt_cfg.sv
hw/rtl/bslt_in_stage.sv
hw/rtl/bslt_core.sv
hw/rtl/button_short_long_press_toggler_top.sv
sim/button_short_long_press_toggler_top_tb.sv
